@@ hdl/bpa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the buddy page allocator.
// No dependencies; every other file refers to this package by scoped names.
package bpa_pkg;

  localparam int PAGES     = 1024;
  localparam int SPAN_LOG2 = $clog2(PAGES);
  localparam int SPAN      = 1 << SPAN_LOG2;
  localparam int NODES     = 2 * SPAN - 1;
  localparam int NODE_W    = SPAN_LOG2 + 1;
  localparam int RUN_W     = SPAN_LOG2 + 1;
  localparam int LVL_W     = $clog2(SPAN_LOG2 + 1);

  // Fixed field widths of the channels.
  localparam int OP_W     = 2;
  localparam int REQ_W    = 11;
  localparam int PAGE_W   = 10;
  localparam int STATUS_W = 2;

  // Configuration port.
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;
  localparam int REG_USABLE_PAGES = 0;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_UNALLOC = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_BUILD,
    S_IDLE,
    S_CHECK,
    S_DESC,
    S_MARK,
    S_ASC,
    S_FIN
  } state_t;

  typedef struct packed {
    logic             alloc;
    logic [RUN_W-1:0] run;
  } node_entry_t;

endpackage

@@ hdl/bpa_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces of the buddy page allocator.
// Depends on bpa_pkg for the field widths.
interface bpa_req_if;
  logic                         valid;
  logic                         ready;
  logic [bpa_pkg::OP_W-1:0]     operation;
  logic [bpa_pkg::REQ_W-1:0]    request_pages;
  logic [bpa_pkg::PAGE_W-1:0]   page_index;

  modport source (output valid, operation, request_pages, page_index, input ready);
  modport sink   (input valid, operation, request_pages, page_index, output ready);
endinterface

interface bpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bpa_pkg::STATUS_W-1:0] status;
  logic [bpa_pkg::PAGE_W-1:0]   start_page;
  logic [bpa_pkg::REQ_W-1:0]    granted_pages;
  logic [bpa_pkg::REQ_W-1:0]    remaining_pages;

  modport source (output valid, status, start_page, granted_pages, remaining_pages,
                  input ready);
  modport sink   (input valid, status, start_page, granted_pages, remaining_pages,
                  output ready);
endinterface

@@ hdl/buddy_page_allocator_top.sv @@
`timescale 1ns / 1ps
// Allocate and free walk one tree level per cycle down through the two-port node
// memory, then write one node per level on the way up. Errors found at the root skip
// the walk and go straight to the response. One request is in work at a time;
// the response register lets the next request in while a response waits to be taken.
// Rebuild, and the pass that follows reset, write all 2047 nodes one per cycle;
// request ready stays low during that pass. Reset sets usable_pages to 1024.
module buddy_page_allocator_top (
  input  logic                        clk,
  input  logic                        rst,
  bpa_req_if.sink                     req,
  bpa_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0] paddr,
  input  logic [bpa_pkg::PDATA_W-1:0] pwdata,
  output logic [bpa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int NW = bpa_pkg::NODE_W;
  localparam int RW = bpa_pkg::RUN_W;
  localparam int LW = bpa_pkg::LVL_W;
  localparam int BW = bpa_pkg::SPAN_LOG2;

  // Largest free run below a node right after a rebuild with the first lim pages free.
  // The free pages under a node form a prefix, so the run is the top power of two in it.
  function automatic logic [RW-1:0] build_run(input logic [NW-1:0] addr,
                                              input logic [RW-1:0] lim);
    logic [NW-1:0] v;
    logic [LW-1:0] d;
    logic [RW-1:0] j;
    logic [RW-1:0] base;
    logic [RW-1:0] sp;
    logic [RW-1:0] f;
    logic [RW-1:0] run;
    v = addr + 1'b1;
    d = '0;
    for (int i = 0; i < NW; i++) begin
      if (v[i]) d = LW'(i);
    end
    j    = RW'(v) ^ (RW'(1) << d);
    base = j << (LW'(BW) - d);
    sp   = RW'(bpa_pkg::SPAN) >> d;
    if (lim > base) begin
      f = ((lim - base) > sp) ? sp : (lim - base);
    end else begin
      f = '0;
    end
    run = '0;
    for (int i = 0; i < RW; i++) begin
      if (f[i]) run = RW'(1) << i;
    end
    return run;
  endfunction

  // Configuration register.
  localparam logic [bpa_pkg::PADDR_W-1:0] PADDR_W_ADDR =
    bpa_pkg::PADDR_W'(bpa_pkg::REG_USABLE_PAGES * 4);

  logic [RW-1:0] usable_pages;
  logic          cfg_hit;

  assign cfg_hit = (paddr == PADDR_W_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_pages <= RW'(1024);
    end else if (psel && penable && pwrite && cfg_hit) begin
      usable_pages <= pwdata[RW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = cfg_hit ? bpa_pkg::PDATA_W'(usable_pages) : '0;

  // Node memory: one write port, two registered read ports.
  bpa_pkg::node_entry_t mem [bpa_pkg::NODES];
  bpa_pkg::node_entry_t rd_a, rd_b, wr_data;
  logic [NW-1:0]        rd_addr_a, rd_addr_b, wr_addr;
  logic                 wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  // Control and datapath registers.
  bpa_pkg::state_t  state, state_next;
  logic [bpa_pkg::OP_W-1:0]   op, op_next;
  logic [bpa_pkg::REQ_W-1:0]  n, n_next;
  logic [bpa_pkg::PAGE_W-1:0] pos, pos_next;
  logic [NW-1:0]    node, node_next;
  logic [BW-1:0]    base, base_next;
  logic [RW-1:0]    span, span_next;
  logic [LW-1:0]    depth, depth_next;
  logic [RW-1:0]    cur_run, cur_run_next;
  logic [RW-1:0]    free_count, free_count_next;
  logic [NW-1:0]    build_addr, build_addr_next;
  logic [RW-1:0]    build_lim, build_lim_next;
  logic             build_report, build_report_next;
  bpa_pkg::status_t res_status, res_status_next;
  logic [BW-1:0]    res_start, res_start_next;
  logic [RW-1:0]    res_granted, res_granted_next;

  // Sibling runs seen on the way down, one per tree depth, used on the way up.
  logic [RW-1:0] sib [bpa_pkg::SPAN_LOG2 + 1];
  logic          sib_we;
  logic [LW-1:0] sib_idx;
  logic [RW-1:0] sib_val;

  logic out_load;

  // Path arithmetic.
  logic [RW-1:0] half, pspan, merged, sib_run, fsum_sat;
  logic [RW:0]   pair_sum, fsum;
  logic [NW-1:0] left_idx, right_idx, child_idx, gl_idx, gr_idx, parent_idx;
  logic          go_right_pos, fit_l, fit_r, is_alloc, take_right;
  bpa_pkg::node_entry_t child_ent;
  logic [RW-1:0] other_run;

  assign half         = span >> 1;
  assign left_idx     = NW'({node, 1'b0} + 1'b1);
  assign right_idx    = left_idx + 1'b1;
  assign go_right_pos = RW'(pos) >= (RW'(base) + half);
  assign fit_l        = rd_a.run >= n;
  assign fit_r        = rd_b.run >= n;
  assign is_alloc     = (op == bpa_pkg::OP_ALLOC);
  assign take_right   = is_alloc ? !fit_l : go_right_pos;
  assign child_idx    = take_right ? right_idx : left_idx;
  assign child_ent    = take_right ? rd_b : rd_a;
  assign other_run    = take_right ? rd_a.run : rd_b.run;
  assign gl_idx       = NW'({child_idx, 1'b0} + 1'b1);
  assign gr_idx       = gl_idx + 1'b1;
  assign parent_idx   = (node - 1'b1) >> 1;
  assign pspan        = span << 1;
  assign sib_run      = sib[depth];
  assign pair_sum     = {1'b0, cur_run} + {1'b0, sib_run};
  assign merged       = (pair_sum == {1'b0, pspan}) ? pspan :
                        ((cur_run > sib_run) ? cur_run : sib_run);
  assign fsum         = {1'b0, free_count} + {1'b0, n};
  assign fsum_sat     = (fsum > (RW + 1)'(bpa_pkg::PAGES)) ? RW'(bpa_pkg::PAGES) : fsum[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bpa_pkg::S_BUILD;
      build_addr   <= '0;
      build_lim    <= RW'(bpa_pkg::PAGES);
      build_report <= 1'b0;
      free_count   <= RW'(bpa_pkg::PAGES);
    end else begin
      state        <= state_next;
      build_addr   <= build_addr_next;
      build_lim    <= build_lim_next;
      build_report <= build_report_next;
      free_count   <= free_count_next;
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    n           <= n_next;
    pos         <= pos_next;
    node        <= node_next;
    base        <= base_next;
    span        <= span_next;
    depth       <= depth_next;
    cur_run     <= cur_run_next;
    res_status  <= res_status_next;
    res_start   <= res_start_next;
    res_granted <= res_granted_next;
    if (sib_we) sib[sib_idx] <= sib_val;
  end

  always_comb begin
    state_next        = state;
    op_next           = op;
    n_next            = n;
    pos_next          = pos;
    node_next         = node;
    base_next         = base;
    span_next         = span;
    depth_next        = depth;
    cur_run_next      = cur_run;
    free_count_next   = free_count;
    build_addr_next   = build_addr;
    build_lim_next    = build_lim;
    build_report_next = build_report;
    res_status_next   = res_status;
    res_start_next    = res_start;
    res_granted_next  = res_granted;
    rd_addr_a         = '0;
    rd_addr_b         = '0;
    wr_en             = 1'b0;
    wr_addr           = node;
    wr_data           = '{alloc: 1'b0, run: '0};
    sib_we            = 1'b0;
    sib_idx           = depth + 1'b1;
    sib_val           = other_run;
    req.ready         = 1'b0;
    out_load          = 1'b0;

    case (state)
      bpa_pkg::S_BUILD: begin
        wr_en           = 1'b1;
        wr_addr         = build_addr;
        wr_data         = '{alloc: 1'b0, run: build_run(build_addr, build_lim)};
        build_addr_next = build_addr + 1'b1;
        if (build_addr == NW'(bpa_pkg::NODES - 1)) begin
          free_count_next = build_lim;
          state_next      = build_report ? bpa_pkg::S_FIN : bpa_pkg::S_IDLE;
        end
      end

      bpa_pkg::S_IDLE: begin
        req.ready = 1'b1;
        rd_addr_a = '0;
        if (req.valid) begin
          op_next          = req.operation;
          n_next           = req.request_pages;
          pos_next         = req.page_index;
          node_next        = '0;
          base_next        = '0;
          span_next        = RW'(bpa_pkg::SPAN);
          depth_next       = '0;
          res_status_next  = bpa_pkg::STAT_OK;
          res_start_next   = '0;
          res_granted_next = '0;
          if (req.operation == bpa_pkg::OP_REBUILD) begin
            build_lim_next    = (usable_pages > RW'(bpa_pkg::PAGES)) ?
                                RW'(bpa_pkg::PAGES) : usable_pages;
            build_addr_next   = '0;
            build_report_next = 1'b1;
            state_next        = bpa_pkg::S_BUILD;
          end else begin
            state_next = bpa_pkg::S_CHECK;
          end
        end
      end

      // The root entry is on read port A.
      bpa_pkg::S_CHECK: begin
        rd_addr_a = left_idx;
        rd_addr_b = right_idx;
        case (op)
          bpa_pkg::OP_ALLOC: begin
            if (n == '0 || n > free_count || n > rd_a.run) begin
              res_status_next = bpa_pkg::STAT_NOSPACE;
              state_next      = bpa_pkg::S_FIN;
            end else if (span > RW'(1)) begin
              state_next = bpa_pkg::S_DESC;
            end else begin
              state_next = bpa_pkg::S_MARK;
            end
          end
          bpa_pkg::OP_FREE: begin
            if (n == '0) begin
              res_status_next = bpa_pkg::STAT_NOSPACE;
              state_next      = bpa_pkg::S_FIN;
            end else if (RW'(pos) >= RW'(bpa_pkg::SPAN)) begin
              res_status_next = bpa_pkg::STAT_UNALLOC;
              state_next      = bpa_pkg::S_FIN;
            end else if (rd_a.alloc) begin
              state_next = bpa_pkg::S_MARK;
            end else if (span <= RW'(1)) begin
              res_status_next = bpa_pkg::STAT_UNALLOC;
              state_next      = bpa_pkg::S_FIN;
            end else begin
              state_next = bpa_pkg::S_DESC;
            end
          end
          default: begin
            res_status_next = bpa_pkg::STAT_NOSPACE;
            state_next      = bpa_pkg::S_FIN;
          end
        endcase
      end

      // Both children of node are on the read ports. Allocate goes left first to a
      // child that fits; free follows the page index.
      bpa_pkg::S_DESC: begin
        rd_addr_a = gl_idx;
        rd_addr_b = gr_idx;
        if (is_alloc && !fit_l && !fit_r) begin
          state_next = bpa_pkg::S_MARK;
        end else begin
          sib_we     = 1'b1;
          node_next  = child_idx;
          base_next  = take_right ? (base + BW'(half)) : base;
          span_next  = half;
          depth_next = depth + 1'b1;
          if (is_alloc) begin
            state_next = (half > RW'(1)) ? bpa_pkg::S_DESC : bpa_pkg::S_MARK;
          end else if (child_ent.alloc) begin
            state_next = bpa_pkg::S_MARK;
          end else if (half <= RW'(1)) begin
            res_status_next = bpa_pkg::STAT_UNALLOC;
            state_next      = bpa_pkg::S_FIN;
          end
        end
      end

      bpa_pkg::S_MARK: begin
        wr_en            = 1'b1;
        wr_addr          = node;
        res_start_next   = base;
        res_granted_next = span;
        if (is_alloc) begin
          wr_data         = '{alloc: 1'b1, run: '0};
          cur_run_next    = '0;
          free_count_next = free_count - n;
        end else begin
          wr_data         = '{alloc: 1'b0, run: span};
          cur_run_next    = span;
          free_count_next = fsum_sat;
        end
        state_next = (node == '0) ? bpa_pkg::S_FIN : bpa_pkg::S_ASC;
      end

      // Ancestors on the path are never marked, so the parent is written unmarked.
      bpa_pkg::S_ASC: begin
        wr_en        = 1'b1;
        wr_addr      = parent_idx;
        wr_data      = '{alloc: 1'b0, run: merged};
        node_next    = parent_idx;
        span_next    = pspan;
        depth_next   = depth - 1'b1;
        cur_run_next = merged;
        if (parent_idx == '0) state_next = bpa_pkg::S_FIN;
      end

      bpa_pkg::S_FIN: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = bpa_pkg::S_IDLE;
        end
      end

      default: state_next = bpa_pkg::S_IDLE;
    endcase
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status          <= res_status;
      rsp.start_page      <= res_start;
      rsp.granted_pages   <= res_granted;
      rsp.remaining_pages <= free_count;
    end
  end

endmodule

@@ hdl/bpa_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the buddy page allocator, bound to its top level.
// Depends on bpa_pkg and on buddy_page_allocator_top.
module bpa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [bpa_pkg::STATUS_W-1:0] status,
  input logic [bpa_pkg::PAGE_W-1:0]   start_page,
  input logic [bpa_pkg::REQ_W-1:0]    granted_pages,
  input logic [bpa_pkg::REQ_W-1:0]    remaining_pages
);

  // The node memory is rebuilt after reset, so no request may enter right away.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request ready high right after reset");

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // A granted or freed block is a buddy node: power-of-two size, aligned start.
  a_block_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == bpa_pkg::STAT_OK && granted_pages != '0 |->
      $onehot(granted_pages) &&
      ((bpa_pkg::REQ_W'(start_page) & (granted_pages - 1'b1)) == '0))
    else $error("block size or alignment broken");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(start_page) &&
      $stable(granted_pages) && $stable(remaining_pages))
    else $error("stalled response changed");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .status          (rsp.status),
  .start_page      (rsp.start_page),
  .granted_pages   (rsp.granted_pages),
  .remaining_pages (rsp.remaining_pages)
);
